/* rtl/lcd_pkg.sv */
// Shared types and constants for the loop chunk dispatcher.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package lcd_pkg;

  localparam int THREADS    = 4;
  localparam int THREAD_LOG = $clog2(THREADS);
  localparam int THREAD_W   = 2;
  localparam int IDX_W      = 48;  // running index, wide enough for a full overshoot
  localparam int REM_W      = 33;  // remaining iterations of a live loop
  localparam int LEN_W      = 31;  // largest guided chunk length
  localparam int SPAN_W     = 47;  // length times step
  localparam int ADDR_W     = 5;

  // Register map (word index)
  localparam logic [2:0] REG_START = 3'd0;
  localparam logic [2:0] REG_END   = 3'd1;
  localparam logic [2:0] REG_STEP  = 3'd2;
  localparam logic [2:0] REG_MODE  = 3'd3;
  localparam logic [2:0] REG_CHUNK = 3'd4;

  // Schedule codes; code three behaves as static
  localparam logic [1:0] MODE_STATIC  = 2'd0;
  localparam logic [1:0] MODE_DYNAMIC = 2'd1;
  localparam logic [1:0] MODE_GUIDED  = 2'd2;

  typedef enum logic {
    OP_RESTART = 1'b0,
    OP_NEXT    = 1'b1
  } op_e;

  typedef struct packed {
    op_e                 op;
    logic [THREAD_W-1:0] thread_id;
  } item_t;

  typedef struct packed {
    logic [31:0] loop_start;
    logic [31:0] loop_end;
    logic [15:0] loop_step;
    logic [1:0]  schedule_mode;
    logic [15:0] chunk_iters;
  } cfg_t;

endpackage

/* rtl/lcd_front.sv */
// Front end: registers and classifies incoming requests before the queue.
// Depends on lcd_pkg.
`timescale 1ns / 1ps

module lcd_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         in_req_type_i,
  input  logic [lcd_pkg::THREAD_W-1:0] in_thread_id_i,
  input  logic                         q_full_i,
  output logic                         push_o,
  output lcd_pkg::item_t               item_o
);

  logic           valid_q;
  lcd_pkg::item_t item_q;
  lcd_pkg::item_t item_d;

  // Holding register only blocks when the queue cannot take its contents
  assign in_stall_o = valid_q && q_full_i;
  assign push_o     = valid_q;
  assign item_o     = item_q;

  always_comb begin
    item_d.op        = in_req_type_i ? lcd_pkg::OP_NEXT : lcd_pkg::OP_RESTART;
    item_d.thread_id = in_thread_id_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      item_q <= item_d;
    end
  end

endmodule

/* rtl/lcd_queue.sv */
// Short FIFO of classified requests between front and back end.
// Depends on lcd_pkg.
`timescale 1ns / 1ps

module lcd_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  lcd_pkg::item_t push_item_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           head_valid_o,
  output lcd_pkg::item_t head_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  lcd_pkg::item_t   mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             wr_en, rd_en;

  assign full_o       = (cnt_q == CNT_W'(DEPTH));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_ptr_q];
  assign wr_en        = push_i && !full_o;
  assign rd_en        = pop_i && head_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (rd_en) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (wr_en && !rd_en) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (rd_en && !wr_en) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

/* rtl/lcd_back.sv */
// Back end: scheduler state, chunk arithmetic and the result register.
// Depends on lcd_pkg.
`timescale 1ns / 1ps

module lcd_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  lcd_pkg::cfg_t                cfg_i,
  input  logic                         cfg_wr_i,
  input  logic                         head_valid_i,
  input  lcd_pkg::item_t               head_i,
  output logic                         pop_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         out_granted_o,
  output logic [lcd_pkg::THREAD_W-1:0] out_chunk_thread_o,
  output logic signed [31:0]           out_chunk_first_o,
  output logic signed [31:0]           out_chunk_last_o,
  output logic                         out_loop_done_o
);

  localparam int IDX_W  = lcd_pkg::IDX_W;
  localparam int REM_W  = lcd_pkg::REM_W;
  localparam int LEN_W  = lcd_pkg::LEN_W;
  localparam int SPAN_W = lcd_pkg::SPAN_W;
  localparam int TH_W   = lcd_pkg::THREAD_W;

  typedef enum logic {ST_RUN, ST_MUL} state_e;
  typedef enum logic [1:0] {SEL_STAT, SEL_DYN, SEL_GUID} sel_e;
  typedef enum logic [2:0] {ACT_IDLE, ACT_RESTART, ACT_REFUSE, ACT_GRANT, ACT_LOAD} act_e;

  state_e                  state_q;
  sel_e                    sel_q;
  logic signed [IDX_W-1:0] next_idx_q;
  logic [15:0]             static_len_q;
  logic [TH_W-1:0]         rr_q;
  logic                    exh_q, chk_done_q;
  logic                    stat_ok_q, dyn_ok_q, guid_ok_q;
  logic [SPAN_W-1:0]       stat_span_q, dyn_span_q, guid_span_q;
  logic [LEN_W-1:0]        len_q;

  logic                    out_valid_q, out_granted_q, out_done_q;
  logic [TH_W-1:0]         out_thread_q;
  logic [31:0]             out_first_q, out_last_q;

  logic [15:0]             step_eff, csize_eff, stat_len_eff, shrink_len;
  logic signed [IDX_W-1:0] end_x, start_x, nxt, last_x;
  logic [IDX_W-1:0]        diff;
  logic [REM_W-1:0]        rem, rem_q4;
  logic [REM_W:0]          rem_up;
  logic [REM_W-1:0]        guid_div;
  logic [LEN_W-1:0]        guid_len;
  logic                    past_end, nxt_exh, shrink, out_free, is_static;
  logic [SPAN_W-1:0]       span, prod;

  act_e                    act;
  logic [LEN_W-1:0]        ld_len;
  sel_e                    ld_sel;
  logic                    ld_chk;
  logic [15:0]             static_new;
  logic [TH_W-1:0]         grant_thread;

  assign step_eff     = (cfg_i.loop_step == '0) ? 16'd1 : cfg_i.loop_step;
  assign csize_eff    = (cfg_i.chunk_iters == '0) ? 16'd1 : cfg_i.chunk_iters;
  assign stat_len_eff = (static_len_q == '0) ? 16'd1 : static_len_q;
  assign end_x   = {{(IDX_W-32){cfg_i.loop_end[31]}}, cfg_i.loop_end};
  assign start_x = {{(IDX_W-32){cfg_i.loop_start[31]}}, cfg_i.loop_start};

  // Remaining count is only meaningful while the index is below the end
  assign diff     = end_x - next_idx_q;
  assign rem      = diff[REM_W-1:0];
  assign past_end = (next_idx_q >= end_x);

  // Static shrink test and new length, only at the top of a round
  assign rem_q4     = rem >> lcd_pkg::THREAD_LOG;
  assign shrink_len = (rem_q4[15:0] == '0) ? 16'd1 : rem_q4[15:0];
  assign shrink     = (rr_q == '0) && !chk_done_q &&
                      (rem < (REM_W'(static_len_q) << lcd_pkg::THREAD_LOG));

  // Guided: ceiling of remaining over thread count, floored at chunk size
  assign rem_up   = {1'b0, rem} + (REM_W+1)'(lcd_pkg::THREADS - 1);
  assign guid_div = REM_W'(rem_up[REM_W:lcd_pkg::THREAD_LOG]);
  assign guid_len = (guid_div[LEN_W-1:0] < LEN_W'(csize_eff)) ?
                    LEN_W'(csize_eff) : guid_div[LEN_W-1:0];

  assign is_static = (cfg_i.schedule_mode != lcd_pkg::MODE_DYNAMIC) &&
                     (cfg_i.schedule_mode != lcd_pkg::MODE_GUIDED);

  assign nxt     = next_idx_q + IDX_W'(span);
  assign nxt_exh = (nxt >= end_x);
  assign last_x  = (nxt > end_x) ? end_x - 1'b1 : nxt - 1'b1;

  assign prod = SPAN_W'(len_q) * SPAN_W'(step_eff);

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    act        = ACT_IDLE;
    ld_len     = len_q;
    ld_sel     = SEL_STAT;
    ld_chk     = 1'b0;
    static_new = static_len_q;
    span       = stat_span_q;
    if (state_q == ST_RUN && head_valid_i) begin
      if (head_i.op == lcd_pkg::OP_RESTART) begin
        act = out_free ? ACT_RESTART : ACT_IDLE;
      end else if (exh_q || past_end) begin
        act = out_free ? ACT_REFUSE : ACT_IDLE;
      end else begin
        case (cfg_i.schedule_mode)
          lcd_pkg::MODE_DYNAMIC: begin
            span = dyn_span_q;
            if (!dyn_ok_q) begin
              act    = ACT_LOAD;
              ld_len = LEN_W'(csize_eff);
              ld_sel = SEL_DYN;
            end else begin
              act = out_free ? ACT_GRANT : ACT_IDLE;
            end
          end
          lcd_pkg::MODE_GUIDED: begin
            span = guid_span_q;
            if (!guid_ok_q) begin
              act    = ACT_LOAD;
              ld_len = guid_len;
              ld_sel = SEL_GUID;
            end else begin
              act = out_free ? ACT_GRANT : ACT_IDLE;
            end
          end
          default: begin
            span = stat_span_q;
            if (!stat_ok_q) begin
              act        = ACT_LOAD;
              ld_len     = LEN_W'(stat_len_eff);
              static_new = stat_len_eff;
            end else if (shrink) begin
              act        = ACT_LOAD;
              ld_len     = LEN_W'(shrink_len);
              static_new = shrink_len;
              ld_chk     = 1'b1;
            end else begin
              act = out_free ? ACT_GRANT : ACT_IDLE;
            end
          end
        endcase
      end
    end
  end

  assign grant_thread = is_static ? rr_q : head_i.thread_id;
  assign pop_o = (act == ACT_RESTART) || (act == ACT_REFUSE) || (act == ACT_GRANT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_RUN;
      sel_q         <= SEL_STAT;
      next_idx_q    <= '0;
      static_len_q  <= '0;
      rr_q          <= '0;
      exh_q         <= 1'b0;
      chk_done_q    <= 1'b0;
      stat_ok_q     <= 1'b0;
      dyn_ok_q      <= 1'b0;
      guid_ok_q     <= 1'b0;
      stat_span_q   <= '0;
      dyn_span_q    <= '0;
      guid_span_q   <= '0;
      len_q         <= '0;
      out_valid_q   <= 1'b0;
      out_granted_q <= 1'b0;
      out_done_q    <= 1'b0;
      out_thread_q  <= '0;
      out_first_q   <= '0;
      out_last_q    <= '0;
    end else begin
      if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_RUN: begin
          case (act)
            ACT_RESTART: begin
              next_idx_q    <= start_x;
              static_len_q  <= cfg_i.chunk_iters;
              rr_q          <= '0;
              exh_q         <= (start_x >= end_x);
              chk_done_q    <= 1'b0;
              stat_ok_q     <= 1'b0;
              guid_ok_q     <= 1'b0;
              out_valid_q   <= 1'b1;
              out_granted_q <= 1'b0;
              out_thread_q  <= '0;
              out_first_q   <= '0;
              out_last_q    <= '0;
              out_done_q    <= (start_x >= end_x);
            end
            ACT_REFUSE: begin
              exh_q         <= 1'b1;
              out_valid_q   <= 1'b1;
              out_granted_q <= 1'b0;
              out_thread_q  <= '0;
              out_first_q   <= '0;
              out_last_q    <= '0;
              out_done_q    <= 1'b1;
            end
            ACT_GRANT: begin
              next_idx_q    <= nxt;
              exh_q         <= nxt_exh;
              chk_done_q    <= 1'b0;
              if (is_static) begin
                rr_q <= (rr_q == TH_W'(lcd_pkg::THREADS - 1)) ? '0 : rr_q + 1'b1;
              end
              if (cfg_i.schedule_mode == lcd_pkg::MODE_GUIDED) begin
                guid_ok_q <= 1'b0;
              end
              out_valid_q   <= 1'b1;
              out_granted_q <= 1'b1;
              out_thread_q  <= grant_thread;
              out_first_q   <= next_idx_q[31:0];
              out_last_q    <= last_x[31:0];
              out_done_q    <= nxt_exh;
            end
            ACT_LOAD: begin
              len_q        <= ld_len;
              sel_q        <= ld_sel;
              static_len_q <= static_new;
              if (ld_chk) begin
                chk_done_q <= 1'b1;
              end
              state_q      <= ST_MUL;
            end
            default: ;
          endcase
        end
        ST_MUL: begin
          case (sel_q)
            SEL_DYN: begin
              dyn_span_q <= prod;
              dyn_ok_q   <= 1'b1;
            end
            SEL_GUID: begin
              guid_span_q <= prod;
              guid_ok_q   <= 1'b1;
            end
            default: begin
              stat_span_q <= prod;
              stat_ok_q   <= 1'b1;
            end
          endcase
          state_q <= ST_RUN;
        end
        default: state_q <= ST_RUN;
      endcase
      // Any register write invalidates the cached spans
      if (cfg_wr_i) begin
        stat_ok_q <= 1'b0;
        dyn_ok_q  <= 1'b0;
        guid_ok_q <= 1'b0;
      end
    end
  end

  assign out_valid_o        = out_valid_q;
  assign out_granted_o      = out_granted_q;
  assign out_chunk_thread_o = out_thread_q;
  assign out_chunk_first_o  = out_first_q;
  assign out_chunk_last_o   = out_last_q;
  assign out_loop_done_o    = out_done_q;

endmodule

/* rtl/loop_chunk_dispatcher.sv */
// Loop chunk dispatcher: hands out iteration chunks to worker threads.
// Request channel (in_*): one transaction per request, restart or next chunk.
// Result channel (out_*): exactly one transaction per request, in order.
// Registers on an APB-style port: start, end, step, mode, chunk length.
// Path: a request passes the front holding register and the queue, and its
// result is registered on out_*; a span recompute adds the load and multiply
// states. Throughput: one request per cycle for restarts, refusals, and static
// and dynamic grants while the cached length-times-step span holds and the
// result side does not stall. A new span passes a length select, then the
// single 31x16 multiplier: every guided grant, the first static grant after
// reset, a restart or a register write, the first dynamic grant after reset or
// a register write, and each static shrink.
// Reset: all scheduler state clears, registers take their reset values, both
// channels come up empty. Stall on the result side holds the result register;
// the request queue keeps taking transactions until it fills, then in_stall_o
// rises. The user must see that registers are written only while no request
// is outstanding; the block itself does not enforce it.
// Depends on lcd_pkg, lcd_front, lcd_queue and lcd_back.
`timescale 1ns / 1ps

module loop_chunk_dispatcher #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // request channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         in_req_type_i,
  input  logic [lcd_pkg::THREAD_W-1:0] in_thread_id_i,
  // result channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         out_granted_o,
  output logic [lcd_pkg::THREAD_W-1:0] out_chunk_thread_o,
  output logic signed [31:0]           out_chunk_first_o,
  output logic signed [31:0]           out_chunk_last_o,
  output logic                         out_loop_done_o,
  // register port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lcd_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  lcd_pkg::cfg_t  cfg_q;
  logic           cfg_wr;
  logic [2:0]     reg_idx;

  logic           front_push, q_full, q_pop, q_head_valid;
  lcd_pkg::item_t front_item, q_head;

  // ---------------------------------------------------------------------
  // Register port: pready tied high, write on the access phase
  // ---------------------------------------------------------------------
  assign pready  = 1'b1;
  assign reg_idx = paddr[lcd_pkg::ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.loop_start    <= '0;
      cfg_q.loop_end      <= '0;
      cfg_q.loop_step     <= 16'd1;
      cfg_q.schedule_mode <= lcd_pkg::MODE_STATIC;
      cfg_q.chunk_iters   <= 16'd1;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        lcd_pkg::REG_START: cfg_q.loop_start    <= pwdata;
        lcd_pkg::REG_END:   cfg_q.loop_end      <= pwdata;
        lcd_pkg::REG_STEP:  cfg_q.loop_step     <= pwdata[15:0];
        lcd_pkg::REG_MODE:  cfg_q.schedule_mode <= pwdata[1:0];
        lcd_pkg::REG_CHUNK: cfg_q.chunk_iters   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      lcd_pkg::REG_START: prdata = cfg_q.loop_start;
      lcd_pkg::REG_END:   prdata = cfg_q.loop_end;
      lcd_pkg::REG_STEP:  prdata = {16'd0, cfg_q.loop_step};
      lcd_pkg::REG_MODE:  prdata = {30'd0, cfg_q.schedule_mode};
      lcd_pkg::REG_CHUNK: prdata = {16'd0, cfg_q.chunk_iters};
      default:            prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Front end -> queue -> back end
  // ---------------------------------------------------------------------
  lcd_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .in_req_type_i  (in_req_type_i),
    .in_thread_id_i (in_thread_id_i),
    .q_full_i       (q_full),
    .push_o         (front_push),
    .item_o         (front_item)
  );

  lcd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (front_push),
    .push_item_i  (front_item),
    .full_o       (q_full),
    .pop_i        (q_pop),
    .head_valid_o (q_head_valid),
    .head_o       (q_head)
  );

  lcd_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg_q),
    .cfg_wr_i           (cfg_wr),
    .head_valid_i       (q_head_valid),
    .head_i             (q_head),
    .pop_o              (q_pop),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .out_granted_o      (out_granted_o),
    .out_chunk_thread_o (out_chunk_thread_o),
    .out_chunk_first_o  (out_chunk_first_o),
    .out_chunk_last_o   (out_chunk_last_o),
    .out_loop_done_o    (out_loop_done_o)
  );

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  // A granted chunk is never empty
  a_chunk_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_granted_o |-> out_chunk_first_o <= out_chunk_last_o)
    else $error("granted chunk has first above last");

  // A granted chunk stays inside the loop bound
  a_chunk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_granted_o |-> out_chunk_last_o < $signed(cfg_q.loop_end))
    else $error("granted chunk runs past loop end");

  // Results without a grant carry no chunk
  a_no_grant_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_granted_o |->
      out_chunk_thread_o == '0 && out_chunk_first_o == '0 && out_chunk_last_o == '0)
    else $error("refused transaction carries chunk data");

  // The queue never pops when nothing is queued
  a_pop_has_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_head_valid)
    else $error("back end consumed from an empty queue");

endmodule

/* dv/lcd_checker.sv */
// Checker for the loop chunk dispatcher: mirrors the register port, predicts
// every result from the accepted requests and compares it field by field.
// Depends on lcd_pkg.
`timescale 1ns / 1ps

module lcd_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  logic                         in_req_type_i,
  input  logic [lcd_pkg::THREAD_W-1:0] in_thread_id_i,
  input  logic                         out_valid_i,
  input  logic                         out_stall_i,
  input  logic                         out_granted_i,
  input  logic [lcd_pkg::THREAD_W-1:0] out_chunk_thread_i,
  input  logic signed [31:0]           out_chunk_first_i,
  input  logic signed [31:0]           out_chunk_last_i,
  input  logic                         out_loop_done_i,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic                         pready,
  input  logic [lcd_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                  pwdata,
  output int                           fail_count_o,
  output int                           pending_o
);

  typedef struct packed {
    logic                         granted;
    logic [lcd_pkg::THREAD_W-1:0] thr;
    logic signed [31:0]           first;
    logic signed [31:0]           last;
    logic                         done;
  } chunk_grant_t;

  lcd_pkg::cfg_t shadow_cfg;
  longint        next_pos;
  longint        static_len;
  int            rr_thread;
  bit            loop_spent;
  chunk_grant_t  grants_due[$];

  // Scheduler model: updates the running state, returns the grant it causes
  function automatic chunk_grant_t next_grant(lcd_pkg::op_e op,
                                              logic [lcd_pkg::THREAD_W-1:0] tid);
    chunk_grant_t g;
    longint       loop_hi;
    longint       step;
    longint       csize;
    longint       remaining;
    longint       len;
    longint       hi_idx;
    longint       first;
    logic [lcd_pkg::THREAD_W-1:0] thr;
    loop_hi = longint'($signed(shadow_cfg.loop_end));
    step    = (shadow_cfg.loop_step == 0) ? 1 : shadow_cfg.loop_step;
    csize   = (shadow_cfg.chunk_iters == 0) ? 1 : shadow_cfg.chunk_iters;
    g       = '0;
    if (op == lcd_pkg::OP_RESTART) begin
      next_pos   = longint'($signed(shadow_cfg.loop_start));
      static_len = shadow_cfg.chunk_iters;
      rr_thread  = 0;
      loop_spent = next_pos >= loop_hi;
      g.done     = loop_spent;
      return g;
    end
    if (loop_spent || next_pos >= loop_hi) begin
      loop_spent = 1'b1;
      g.done     = 1'b1;
      return g;
    end
    remaining = loop_hi - next_pos;
    case (shadow_cfg.schedule_mode)
      lcd_pkg::MODE_DYNAMIC: begin
        len = csize;
        thr = tid;
      end
      lcd_pkg::MODE_GUIDED: begin
        len = (remaining + lcd_pkg::THREADS - 1) / lcd_pkg::THREADS;
        if (len < csize) len = csize;
        thr = tid;
      end
      default: begin
        if (static_len == 0) static_len = 1;
        // shrink once fewer than a full round of chunks is left
        if (rr_thread == 0 && remaining < lcd_pkg::THREADS * static_len) begin
          static_len = remaining / lcd_pkg::THREADS;
          if (static_len < 1) static_len = 1;
        end
        len       = static_len;
        thr       = rr_thread[lcd_pkg::THREAD_W-1:0];
        rr_thread = (rr_thread + 1) % lcd_pkg::THREADS;
      end
    endcase
    first  = next_pos;
    hi_idx = first + len * step - 1;
    if (hi_idx >= loop_hi) hi_idx = loop_hi - 1;
    next_pos = first + len * step;
    if (next_pos >= loop_hi) loop_spent = 1'b1;
    g.granted = 1'b1;
    g.thr     = thr;
    g.first   = first[31:0];
    g.last    = hi_idx[31:0];
    g.done    = loop_spent;
    return g;
  endfunction

  task automatic flag_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    fail_count_o++;
  endtask

  task automatic check_field(input string name, input logic signed [63:0] got,
                             input logic signed [63:0] want);
    if (got !== want) flag_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    chunk_grant_t want;
    if (!rst_ni) begin
      shadow_cfg   = '{loop_start: 32'd0, loop_end: 32'd0, loop_step: 16'd1,
                       schedule_mode: lcd_pkg::MODE_STATIC, chunk_iters: 16'd1};
      next_pos     = 0;
      static_len   = 0;
      rr_thread    = 0;
      loop_spent   = 1'b0;
      fail_count_o = 0;
      grants_due.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[lcd_pkg::ADDR_W-1:2])
          lcd_pkg::REG_START: shadow_cfg.loop_start    = pwdata;
          lcd_pkg::REG_END:   shadow_cfg.loop_end      = pwdata;
          lcd_pkg::REG_STEP:  shadow_cfg.loop_step     = pwdata[15:0];
          lcd_pkg::REG_MODE:  shadow_cfg.schedule_mode = pwdata[1:0];
          lcd_pkg::REG_CHUNK: shadow_cfg.chunk_iters   = pwdata[15:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i)
        grants_due.push_back(next_grant(lcd_pkg::op_e'(in_req_type_i), in_thread_id_i));
      if (out_valid_i && !out_stall_i) begin
        if (grants_due.size() == 0) begin
          flag_mismatch("result transaction with no request outstanding");
        end else begin
          want = grants_due.pop_front();
          check_field("granted", 64'(out_granted_i), 64'(want.granted));
          check_field("chunk_thread", 64'(out_chunk_thread_i), 64'(want.thr));
          check_field("chunk_first", 64'(out_chunk_first_i), 64'(want.first));
          check_field("chunk_last", 64'(out_chunk_last_i), 64'(want.last));
          check_field("loop_done", 64'(out_loop_done_i), 64'(want.done));
        end
      end
    end
    pending_o = grants_due.size();
  end

endmodule

/* dv/tb_loop_chunk_dispatcher.sv */
// Top of the loop chunk dispatcher testbench: clock, reset, register writes,
// request and result traffic with random idling, and the final verdict.
// Depends on lcd_pkg, loop_chunk_dispatcher and lcd_checker.
`timescale 1ns / 1ps

module tb_loop_chunk_dispatcher;

  // Schedule code three is decoded as static by the block
  localparam logic [1:0] MODE_ALIAS_STATIC = 2'd3;
  // Generous cycle budget: ~1750 requests even under heavy idling, plus the
  // long hold-off and the register writes
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         in_valid_i = 1'b0;
  logic                         in_stall_o;
  logic                         in_req_type_i = 1'b0;
  logic [lcd_pkg::THREAD_W-1:0] in_thread_id_i = '0;
  logic                         out_valid_o;
  logic                         out_stall_i = 1'b0;
  logic                         out_granted_o;
  logic [lcd_pkg::THREAD_W-1:0] out_chunk_thread_o;
  logic signed [31:0]           out_chunk_first_o;
  logic signed [31:0]           out_chunk_last_o;
  logic                         out_loop_done_o;
  logic                         psel = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite = 1'b0;
  logic [lcd_pkg::ADDR_W-1:0]   paddr = '0;
  logic [31:0]                  pwdata = '0;
  logic [31:0]                  prdata;
  logic                         pready;

  int   fail_count;
  int   pending;
  int   cycle_count = 0;
  int   send_idle_pct = 0;  // chance per cycle that the sender holds back
  int   stall_pct = 0;      // chance per cycle that the receiver stalls
  logic hold_on = 1'b0;     // long receiver hold-off in progress
  event start_hold;

  always #10 clk_i = ~clk_i;

  loop_chunk_dispatcher i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .in_req_type_i      (in_req_type_i),
    .in_thread_id_i     (in_thread_id_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .out_granted_o      (out_granted_o),
    .out_chunk_thread_o (out_chunk_thread_o),
    .out_chunk_first_o  (out_chunk_first_o),
    .out_chunk_last_o   (out_chunk_last_o),
    .out_loop_done_o    (out_loop_done_o),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  lcd_checker i_checker (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_i         (in_stall_o),
    .in_req_type_i      (in_req_type_i),
    .in_thread_id_i     (in_thread_id_i),
    .out_valid_i        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .out_granted_i      (out_granted_o),
    .out_chunk_thread_i (out_chunk_thread_o),
    .out_chunk_first_i  (out_chunk_first_o),
    .out_chunk_last_i   (out_chunk_last_o),
    .out_loop_done_i    (out_loop_done_o),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .pready             (pready),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .fail_count_o       (fail_count),
    .pending_o          (pending)
  );

  // Watchdog: a hung handshake ends the run here
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Receiver: random stalls, forced high for the whole of a hold-off
  always @(negedge clk_i) begin
    out_stall_i <= hold_on || ($urandom_range(0, 99) < stall_pct);
  end

  // Hold-off counted on rising edges; the stall driver reads it on falling
  // edges, so the two never race
  initial begin
    forever begin
      @(start_hold);
      @(posedge clk_i);
      hold_on <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk_i);
      hold_on <= 1'b0;
    end
  end

  // All driving tasks start and end just after a falling edge, with nothing
  // assigned yet in that time step.

  // Offer one request, with random idle cycles ahead of it; valid stays high
  // between back-to-back transactions and the payload holds while stalled
  task automatic send_req(input lcd_pkg::op_e op,
                          input logic [lcd_pkg::THREAD_W-1:0] tid);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    in_req_type_i  <= op;
    in_thread_id_i <= tid;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  // Wait until every outstanding result has come back, then let the
  // pipeline settle before touching the registers
  task automatic drain;
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Write all five registers back to back; psel stays high between the
  // access phase of one write and the setup phase of the next
  task automatic write_loop(input logic [31:0] start, input logic [31:0] stop,
                            input logic [15:0] step, input logic [1:0] mode,
                            input logic [15:0] chunk);
    logic [2:0]  idx[5];
    logic [31:0] val[5];
    idx = '{lcd_pkg::REG_START, lcd_pkg::REG_END, lcd_pkg::REG_STEP,
            lcd_pkg::REG_MODE, lcd_pkg::REG_CHUNK};
    val = '{start, stop, {16'd0, step}, {30'd0, mode}, {16'd0, chunk}};
    for (int i = 0; i < 5; i++) begin
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx[i], 2'b00};
      pwdata  <= val[i];
      @(negedge clk_i);
      penable <= 1'b1;
      do @(posedge clk_i); while (!pready);
      @(negedge clk_i);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Random loop: mostly short loops that run out within a segment, with the
  // index and size extremes, zero step or chunk, and empty loops mixed in
  task automatic random_loop;
    longint lo;
    longint hi;
    int     step;
    int     chunk;
    case ($urandom_range(0, 9))
      0:       step = 65535;
      1:       step = 0;
      default: step = $urandom_range(1, 4);
    endcase
    case ($urandom_range(0, 9))
      0:       chunk = 65535;
      1:       chunk = 0;
      default: chunk = $urandom_range(1, 8);
    endcase
    case ($urandom_range(0, 9))
      0:       lo = -64'sd2147483648;
      1:       lo = longint'(int'($urandom()));
      2:       lo = 2147483647 - longint'($urandom_range(0, 60));
      default: lo = longint'($urandom_range(0, 200)) - 100;
    endcase
    case ($urandom_range(0, 9))
      0:       hi = lo - $urandom_range(0, 5);
      1:       hi = 2147483647;
      default: hi = lo + longint'($urandom_range(1, 24)) * ((step == 0) ? 1 : step);
    endcase
    if (hi > 2147483647) hi = 2147483647;
    if (hi < -64'sd2147483648) hi = -64'sd2147483648;
    write_loop(lo[31:0], hi[31:0], step[15:0], 2'($urandom_range(0, 3)), chunk[15:0]);
  endtask

  initial begin
    int sent;

    // Reset held low, then released on a falling edge
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // ---- Directed part ----
    // No restart since reset: the static length is still zero and counts as one
    write_loop(32'sd0, 32'sd10, 16'd1, lcd_pkg::MODE_STATIC, 16'd1);
    send_req(lcd_pkg::OP_NEXT, 2'd2);
    send_req(lcd_pkg::OP_NEXT, 2'd1);
    send_req(lcd_pkg::OP_NEXT, 2'd3);
    drain();

    // Full index range, largest step and chunk, code three as static:
    // first chunk nearly spans the range, second is clipped and ends the loop,
    // then a refused request
    write_loop(32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF, MODE_ALIAS_STATIC, 16'hFFFF);
    send_req(lcd_pkg::OP_RESTART, 2'd3);
    send_req(lcd_pkg::OP_NEXT, 2'd3);
    send_req(lcd_pkg::OP_NEXT, 2'd3);
    send_req(lcd_pkg::OP_NEXT, 2'd3);
    drain();

    // Dynamic with zero step and zero chunk size, one request per thread
    write_loop(32'sd0, 32'sd20, 16'd0, lcd_pkg::MODE_DYNAMIC, 16'd0);
    send_req(lcd_pkg::OP_RESTART, 2'd0);
    for (int t = 0; t < lcd_pkg::THREADS; t++)
      send_req(lcd_pkg::OP_NEXT, t[lcd_pkg::THREAD_W-1:0]);
    drain();

    // Guided: chunk length falls with the remaining count down to the minimum
    write_loop(32'sd5, 32'sd100, 16'd2, lcd_pkg::MODE_GUIDED, 16'd3);
    send_req(lcd_pkg::OP_RESTART, 2'd1);
    send_req(lcd_pkg::OP_NEXT, 2'd3);
    send_req(lcd_pkg::OP_NEXT, 2'd0);
    send_req(lcd_pkg::OP_NEXT, 2'd2);
    send_req(lcd_pkg::OP_NEXT, 2'd1);
    drain();

    // Static shrink when thread 0 comes round with less than a full round left
    write_loop(32'sd0, 32'sd9, 16'd1, lcd_pkg::MODE_STATIC, 16'd2);
    send_req(lcd_pkg::OP_RESTART, 2'd0);
    repeat (5) send_req(lcd_pkg::OP_NEXT, 2'd0);
    drain();

    // Start at or past the end: restart already reports the loop done
    write_loop(32'sd100, -32'sd5, 16'd1, lcd_pkg::MODE_STATIC, 16'd4);
    send_req(lcd_pkg::OP_RESTART, 2'd2);
    send_req(lcd_pkg::OP_NEXT, 2'd1);
    drain();

    // ---- Back-pressure: receiver holds off while requests keep coming ----
    write_loop(32'sd0, 32'sd1000, 16'd1, lcd_pkg::MODE_DYNAMIC, 16'd1);
    -> start_hold;
    send_req(lcd_pkg::OP_RESTART, 2'd0);
    repeat (39) send_req(lcd_pkg::OP_NEXT, 2'($urandom_range(0, 3)));
    drain();

    // ---- Random part: eight phases cycling through the idling patterns ----
    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 70; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 70; end
        default: begin send_idle_pct = 38; stall_pct = 38; end
      endcase
      for (int s = 0; s < 5; s++) begin
        drain();
        random_loop();
        sent = 0;
        // Half the segments carry on the old loop under the new registers
        if ($urandom_range(0, 1)) begin
          send_req(lcd_pkg::OP_RESTART, 2'($urandom_range(0, 3)));
          sent++;
        end
        while (sent < 42) begin
          if ($urandom_range(0, 99) < 10)
            send_req(lcd_pkg::OP_RESTART, 2'($urandom_range(0, 3)));
          else
            send_req(lcd_pkg::OP_NEXT, 2'($urandom_range(0, 3)));
          sent++;
        end
      end
    end

    // Wind down: everything back, then a wait for stray results
    send_idle_pct = 0;
    stall_pct     = 0;
    drain();
    repeat (8) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* loop_chunk_dispatcher.f */
rtl/lcd_pkg.sv
rtl/lcd_front.sv
rtl/lcd_queue.sv
rtl/lcd_back.sv
rtl/loop_chunk_dispatcher.sv
dv/lcd_checker.sv
dv/tb_loop_chunk_dispatcher.sv
